@@ rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: types, constants and defaults.
package bpa_pkg;

  // Field widths of the request and result channels
  localparam int unsigned PADDR_W   = 48;
  localparam int unsigned LEN_W     = 40;
  localparam int unsigned SLOT_W    = 2;

  // Page and bitmap geometry
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BYTE_SHIFT    = 3;
  localparam logic [7:0]  BYTE_FULL     = 8'hFF;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_SEGMENTS_DEF      = 4;
  localparam int unsigned PAGES_PER_SEGMENT_DEF = 1024;
  localparam int unsigned ADDR_BITS_DEF         = 48;

  // Request action codes
  typedef enum logic {
    ACT_SETUP = 1'b0,
    ACT_ALLOC = 1'b1
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEG,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Status of one scanned bitmap byte
  typedef struct packed {
    logic       full;
    logic [2:0] bit_pos;
  } scan_stat_t;

endpackage

@@ rtl/bpa_bitmap_ram.sv @@
// Page usage bitmap: one write port, one read port with registered data.
module bpa_bitmap_ram #(
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bpa_scan_unit.sv @@
// Scan unit: finds the lowest clear bit of a bitmap byte, builds the
// updated byte and the page address of that bit.
module bpa_scan_unit #(
  parameter int unsigned BYTE_W = 7,
  parameter int unsigned AW     = 48
) (
  input  logic [7:0]               bmp_byte,
  input  logic [BYTE_W-1:0]        byte_idx,
  input  logic [AW-1:0]            seg_base,
  output bpa_pkg::scan_stat_t      stat,
  output logic [7:0]               set_byte,
  output logic [AW-1:0]            page_addr
);

  localparam int unsigned OFF_W = BYTE_W + bpa_pkg::BYTE_SHIFT + 1;

  logic [2:0]       pos;
  logic [OFF_W-1:0] page_off;

  // lowest clear bit, LSB first
  always_comb begin
    pos = 3'd0;
    for (int i = bpa_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
      if (!bmp_byte[i]) begin
        pos = 3'(i);
      end
    end
  end

  assign stat.full    = (bmp_byte == bpa_pkg::BYTE_FULL);
  assign stat.bit_pos = pos;
  assign set_byte     = bmp_byte | (8'd1 << pos);

  // page index plus one skips the header page above the base
  assign page_off  = OFF_W'({byte_idx, pos}) + OFF_W'(1);
  assign page_addr = seg_base + (AW'(page_off) << bpa_pkg::PAGE_SHIFT);

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// Bitmap page allocator top level: segment table, sequencer and result register.
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid/in_ready, action, segment, seg_base,     | in
//          | length, available                                 |
//  out     | out_valid/out_ready, found, page_addr             | out
//
// One request at a time. A setup request clears the bitmap bytes of its
// segment in turn (up to PAGES_PER_SEGMENT/8). An allocate request visits
// the segment slots in order and reads their bitmap bytes one by one; the
// bitmap memory read port sets that pace.
// After reset no segment is usable; the bitmap needs no clearing pass.
// A finished result waits in the output register; setup requests are still
// taken meanwhile, a further allocate waits at its end for the register.
module bitmap_page_allocator #(
  parameter int unsigned NUM_SEGMENTS      = bpa_pkg::NUM_SEGMENTS_DEF,
  parameter int unsigned PAGES_PER_SEGMENT = bpa_pkg::PAGES_PER_SEGMENT_DEF,
  parameter int unsigned ADDR_BITS         = bpa_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [bpa_pkg::SLOT_W-1:0]    in_segment,
  input  logic [bpa_pkg::PADDR_W-1:0]   in_seg_base,
  input  logic [bpa_pkg::LEN_W-1:0]     in_length,
  input  logic                          in_available,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [bpa_pkg::PADDR_W-1:0]   out_page_addr
);

  localparam int unsigned BYTES_PER_SEG = PAGES_PER_SEGMENT / bpa_pkg::BITS_PER_BYTE;
  localparam int unsigned BYTE_W   = (BYTES_PER_SEG > 1) ? $clog2(BYTES_PER_SEG) : 1;
  localparam int unsigned NB_W     = $clog2(BYTES_PER_SEG + 1);
  localparam int unsigned SEG_W    = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int unsigned AW       = (ADDR_BITS < bpa_pkg::PADDR_W) ? ADDR_BITS
                                                                    : bpa_pkg::PADDR_W;
  localparam int unsigned RAM_AW   = SEG_W + BYTE_W;
  localparam int unsigned Q_W      = bpa_pkg::LEN_W - bpa_pkg::PAGE_SHIFT
                                     - bpa_pkg::BYTE_SHIFT + 1;
  localparam int unsigned LEN_LO   = bpa_pkg::PAGE_SHIFT + bpa_pkg::BYTE_SHIFT;
  localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_SEGMENTS - 1);

  bpa_pkg::state_t     state_r, state_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic [BYTE_W-1:0]   j_r, j_nxt;
  logic                res_found_r, res_found_nxt;
  logic [AW-1:0]       res_addr_r, res_addr_nxt;
  logic                out_valid_r;
  logic                out_found_r;
  logic [bpa_pkg::PADDR_W-1:0] out_page_addr_r;
  logic                out_load;

  // segment table
  logic [AW-1:0]       seg_base_r   [NUM_SEGMENTS];
  logic [NB_W-1:0]     seg_nb_r     [NUM_SEGMENTS];
  logic                seg_usable_r [NUM_SEGMENTS];

  logic                setup_we;
  logic                slot_ok;
  logic [Q_W-1:0]      setup_q;
  logic [NB_W-1:0]     setup_nb;
  logic                setup_usable;
  logic [SEG_W-1:0]    setup_slot;

  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  bpa_pkg::scan_stat_t scan_stat;
  logic [7:0]          scan_set_byte;
  logic [AW-1:0]       scan_addr;
  logic [NB_W-1:0]     j_next_cnt;

  // page count in bytes: ceil(pages / 8), saturated
  assign setup_q      = Q_W'(in_length[bpa_pkg::LEN_W-1:LEN_LO])
                        + Q_W'(|in_length[LEN_LO-1:bpa_pkg::PAGE_SHIFT]);
  assign setup_nb     = (setup_q > Q_W'(BYTES_PER_SEG)) ? NB_W'(BYTES_PER_SEG)
                                                        : NB_W'(setup_q);
  assign setup_usable = in_available & (|in_length[bpa_pkg::LEN_W-1:bpa_pkg::PAGE_SHIFT]);
  assign slot_ok      = (32'(in_segment) < NUM_SEGMENTS);
  assign setup_slot   = SEG_W'(in_segment);
  assign j_next_cnt   = NB_W'(j_r) + NB_W'(1);

  bpa_bitmap_ram #(
    .ADDR_W (RAM_AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_scan_unit #(
    .BYTE_W (BYTE_W),
    .AW     (AW)
  ) u_scan (
    .bmp_byte  (ram_rdata),
    .byte_idx  (j_r),
    .seg_base  (seg_base_r[seg_r]),
    .stat      (scan_stat),
    .set_byte  (scan_set_byte),
    .page_addr (scan_addr)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: next state, counters and memory control
  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    j_nxt         = j_r;
    res_found_nxt = res_found_r;
    res_addr_nxt  = res_addr_r;
    in_ready      = 1'b0;
    setup_we      = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {seg_r, j_r};
    ram_wdata     = '0;
    ram_raddr     = {seg_r, j_r};
    unique case (state_r)
      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == bpa_pkg::ACT_ALLOC) begin
            seg_nxt   = '0;
            state_nxt = bpa_pkg::ST_SEG;
          end else if (slot_ok) begin
            setup_we = 1'b1;
            seg_nxt  = setup_slot;
            j_nxt    = '0;
            if (setup_nb != '0) begin
              state_nxt = bpa_pkg::ST_CLEAR;
            end
          end
        end
      end
      bpa_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (j_next_cnt == seg_nb_r[seg_r]) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end else begin
          j_nxt = j_r + BYTE_W'(1);
        end
      end
      bpa_pkg::ST_SEG: begin
        if (seg_usable_r[seg_r] && seg_nb_r[seg_r] != '0) begin
          j_nxt     = '0;
          ram_raddr = {seg_r, BYTE_W'(0)};
          state_nxt = bpa_pkg::ST_SCAN;
        end else if (seg_r == LAST_SEG) begin
          res_found_nxt = 1'b0;
          res_addr_nxt  = '0;
          state_nxt     = bpa_pkg::ST_DONE;
        end else begin
          seg_nxt = seg_r + SEG_W'(1);
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (!scan_stat.full) begin
          // claim the page
          ram_we        = 1'b1;
          ram_wdata     = scan_set_byte;
          res_found_nxt = 1'b1;
          res_addr_nxt  = scan_addr;
          state_nxt     = bpa_pkg::ST_DONE;
        end else if (j_next_cnt == seg_nb_r[seg_r]) begin
          if (seg_r == LAST_SEG) begin
            res_found_nxt = 1'b0;
            res_addr_nxt  = '0;
            state_nxt     = bpa_pkg::ST_DONE;
          end else begin
            seg_nxt   = seg_r + SEG_W'(1);
            state_nxt = bpa_pkg::ST_SEG;
          end
        end else begin
          // fetch the next byte while this one is checked
          j_nxt     = j_r + BYTE_W'(1);
          ram_raddr = {seg_r, j_nxt};
        end
      end
      bpa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer datapath registers
  always_ff @(posedge clk) begin
    seg_r       <= seg_nxt;
    j_r         <= j_nxt;
    res_found_r <= res_found_nxt;
    res_addr_r  <= res_addr_nxt;
  end

  // segment table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
        seg_base_r[s]   <= '0;
        seg_nb_r[s]     <= '0;
        seg_usable_r[s] <= 1'b0;
      end
    end else if (setup_we) begin
      seg_base_r[setup_slot]   <= in_seg_base[AW-1:0];
      seg_nb_r[setup_slot]     <= setup_nb;
      seg_usable_r[setup_slot] <= setup_usable;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r     <= res_found_r;
      out_page_addr_r <= bpa_pkg::PADDR_W'(res_addr_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_page_addr = out_page_addr_r;

endmodule

@@ sim/bitmap_page_allocator_tb.sv @@
// Self-checking testbench for the bitmap page allocator: directed table plus random traffic.
module bitmap_page_allocator_tb;

  localparam int unsigned NSEG        = bpa_pkg::NUM_SEGMENTS_DEF;
  localparam int unsigned SEG_BYTES   = bpa_pkg::PAGES_PER_SEGMENT_DEF
                                        / bpa_pkg::BITS_PER_BYTE;
  localparam int unsigned MAP_BYTES   = NSEG * SEG_BYTES;
  localparam int unsigned RAND_ITEMS  = 980;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 150;

  // One request, with an optional hand-written answer for allocations
  typedef struct {
    bpa_pkg::action_t           action;
    logic [bpa_pkg::SLOT_W-1:0]  segment;
    logic [bpa_pkg::PADDR_W-1:0] base;
    logic [bpa_pkg::LEN_W-1:0]   length;
    logic                        available;
    logic                        has_answer;
    logic                        want_found;
    logic [bpa_pkg::PADDR_W-1:0] want_page;
  } request_t;

  typedef struct {
    logic                        found;
    logic [bpa_pkg::PADDR_W-1:0] page;
  } page_grant_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_action;
  logic [bpa_pkg::SLOT_W-1:0]  in_segment;
  logic [bpa_pkg::PADDR_W-1:0] in_seg_base;
  logic [bpa_pkg::LEN_W-1:0]   in_length;
  logic                        in_available;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_found;
  logic [bpa_pkg::PADDR_W-1:0] out_page_addr;

  // Shadow of the segment table and usage bitmap
  logic [bpa_pkg::PADDR_W-1:0] seg_base_shadow [NSEG];
  int unsigned                 seg_pages_shadow [NSEG];
  logic                        seg_usable_shadow [NSEG];
  logic [7:0]                  used_map [MAP_BYTES];

  page_grant_t grants_due [$];
  page_grant_t grant_seen;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_count   = 0;

  // Directed requests; answers typed in where they are obvious
  request_t directed_rows [23] = '{
    // allocate straight after reset: nothing usable
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b1, 1'b0, 48'h0},
    '{bpa_pkg::ACT_SETUP, 2'd0, 48'h1000, 40'h1000, 1'b1, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd2, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1,
      48'h2000},
    // slot 0 unavailable and empty, slot 1 at the top of memory, max length
    '{bpa_pkg::ACT_SETUP, 2'd0, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_SETUP, 2'd1, 48'hFFFF_FFFF_F000, 40'hFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0,
      48'h0},
    // address wraps past the top
    '{bpa_pkg::ACT_ALLOC, 2'd1, 48'h0, 40'h0, 1'b0, 1'b1, 1'b1, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd3, 48'h0, 40'h0, 1'b0, 1'b1, 1'b1, 48'h1000},
    // short segment and unavailable segment
    '{bpa_pkg::ACT_SETUP, 2'd2, 48'h5000, 40'hFFF, 1'b1, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_SETUP, 2'd3, 48'h9000, 40'h10000, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_SETUP, 2'd1, 48'h0, 40'h0, 1'b1, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b1, 1'b0, 48'h0},
    // unaligned base, one page rounds up to a byte of bitmap
    '{bpa_pkg::ACT_SETUP, 2'd3, 48'h1234_5678, 40'h1001, 1'b1, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b1, 1'b1, 48'h1234_6678},
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd1, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd2, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd3, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd1, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd2, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0, 48'h0},
    // every page taken
    '{bpa_pkg::ACT_ALLOC, 2'd3, 48'h0, 40'h0, 1'b0, 1'b1, 1'b0, 48'h0},
    // setting the segment up again frees its pages
    '{bpa_pkg::ACT_SETUP, 2'd3, 48'h1234_5678, 40'h1001, 1'b1, 1'b0, 1'b0, 48'h0},
    '{bpa_pkg::ACT_ALLOC, 2'd0, 48'h0, 40'h0, 1'b0, 1'b1, 1'b1, 48'h1234_6678}
  };

  bitmap_page_allocator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_segment    (in_segment),
    .in_seg_base   (in_seg_base),
    .in_length     (in_length),
    .in_available  (in_available),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_page_addr (out_page_addr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record a segment in the shadow table and clear its bitmap bytes
  function automatic void record_segment(input request_t rq);
    logic [63:0] pages;
    int unsigned slot;
    slot = int'(rq.segment);
    if (slot >= NSEG) return;
    pages = 64'(rq.length >> bpa_pkg::PAGE_SHIFT);
    pages = (pages + 64'd7) & ~64'd7;
    if (pages > 64'(SEG_BYTES * bpa_pkg::BITS_PER_BYTE)) begin
      pages = 64'(SEG_BYTES * bpa_pkg::BITS_PER_BYTE);
    end
    seg_base_shadow[slot]   = rq.base;
    seg_pages_shadow[slot]  = int'(pages);
    seg_usable_shadow[slot] = rq.available
                              && (rq.length >= (bpa_pkg::LEN_W'(1) << bpa_pkg::PAGE_SHIFT));
    for (int i = 0; i < int'(pages >> bpa_pkg::BYTE_SHIFT); i++) begin
      used_map[slot * SEG_BYTES + i] = 8'h00;
    end
  endfunction

  // First-fit search: slots in order, bytes in order, lowest clear bit first
  function automatic page_grant_t claim_free_page();
    page_grant_t g;
    logic [63:0] addr;
    logic [63:0] addr_mask;
    logic [7:0]  b;
    int unsigned nbytes;
    int unsigned idx;
    g.found   = 1'b0;
    g.page    = '0;
    addr_mask = (bpa_pkg::ADDR_BITS_DEF >= 64) ? '1
                : ((64'd1 << bpa_pkg::ADDR_BITS_DEF) - 64'd1);
    for (int s = 0; s < NSEG; s++) begin
      if (!seg_usable_shadow[s]) continue;
      nbytes = seg_pages_shadow[s] >> bpa_pkg::BYTE_SHIFT;
      if (nbytes > SEG_BYTES) nbytes = SEG_BYTES;
      for (int j = 0; j < nbytes; j++) begin
        idx = s * SEG_BYTES + j;
        b   = used_map[idx];
        if (b == bpa_pkg::BYTE_FULL) continue;
        for (int k = 0; k < bpa_pkg::BITS_PER_BYTE; k++) begin
          if (b[k]) continue;
          used_map[idx][k] = 1'b1;
          addr = 64'(seg_base_shadow[s]) + (64'd1 << bpa_pkg::PAGE_SHIFT)
               + (64'(j * bpa_pkg::BITS_PER_BYTE + k) << bpa_pkg::PAGE_SHIFT);
          g.found = 1'b1;
          g.page  = bpa_pkg::PADDR_W'(addr & addr_mask);
          return g;
        end
      end
    end
    return g;
  endfunction

  // Random request: mostly allocations, small segments so they fill up
  function automatic request_t random_request();
    request_t rq;
    rq.action     = ($urandom_range(0, 99) < 12) ? bpa_pkg::ACT_SETUP : bpa_pkg::ACT_ALLOC;
    rq.segment    = bpa_pkg::SLOT_W'($urandom);
    rq.base       = bpa_pkg::PADDR_W'({$urandom, $urandom});
    rq.length     = bpa_pkg::LEN_W'({$urandom, $urandom});
    rq.available  = ($urandom_range(0, 6) != 0);
    rq.has_answer = 1'b0;
    rq.want_found = 1'b0;
    rq.want_page  = '0;
    case ($urandom_range(0, 9))
      0: rq.base[bpa_pkg::PADDR_W-1:22] = '1;
      7, 8, 9: ;
      default: rq.base[bpa_pkg::PAGE_SHIFT-1:0] = '0;
    endcase
    case ($urandom_range(0, 9))
      0: rq.length = bpa_pkg::LEN_W'($urandom_range(0, 4095));
      1: ;
      2: rq.length = bpa_pkg::LEN_W'($urandom_range(1, 128)) << bpa_pkg::PAGE_SHIFT;
      default: rq.length = (bpa_pkg::LEN_W'($urandom_range(1, 48)) << bpa_pkg::PAGE_SHIFT)
                           | bpa_pkg::LEN_W'($urandom_range(0, 4095));
    endcase
    return rq;
  endfunction

  // Drive one request after an idle gap, if any, and wait until it is taken
  task automatic offer_request(input request_t rq);
    page_grant_t g;
    int unsigned gap;
    gap = ((sent_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= rq.action;
    in_segment   <= rq.segment;
    in_seg_base  <= rq.base;
    in_length    <= rq.length;
    in_available <= rq.available;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (rq.action == bpa_pkg::ACT_SETUP) begin
      record_segment(rq);
    end else begin
      g = claim_free_page();
      if (rq.has_answer) begin
        g.found = rq.want_found;
        g.page  = rq.want_page;
      end
      grants_due.push_back(g);
    end
    @(negedge clk);
  endtask

  // Hold off new requests until every outstanding page has come back
  task automatic drain_grants();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result checker and quiet-cycle counter
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: found %0d page_addr 0x%0h", out_found, out_page_addr);
        fail_count++;
      end else begin
        grant_seen = grants_due.pop_front();
        if (out_found !== grant_seen.found) begin
          $error("found: expected %0d, got %0d", grant_seen.found, out_found);
          fail_count++;
        end
        if (out_page_addr !== grant_seen.page) begin
          $error("page_addr: expected 0x%0h, got 0x%0h", grant_seen.page, out_page_addr);
          fail_count++;
        end
      end
    end
  end

  // Result sink with random back-pressure, no stalls in some stretches
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken     = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = ((taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Watchdog: too long without any handshake
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    for (int i = 0; i < MAP_BYTES; i++) used_map[i] = 8'h00;
    for (int s = 0; s < NSEG; s++) begin
      seg_base_shadow[s]   = '0;
      seg_pages_shadow[s]  = 0;
      seg_usable_shadow[s] = 1'b0;
    end
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = bpa_pkg::ACT_SETUP;
    in_segment   = '0;
    in_seg_base  = '0;
    in_length    = '0;
    in_available = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) offer_request(directed_rows[i]);
    drain_grants();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      offer_request(random_request());
      if (n % 100 == 99) drain_grants();
    end
    in_valid <= 1'b0;

    // let the last results and any setup clearing finish
    while (grants_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (grants_due.size() != 0) begin
      $error("%0d results never arrived", grants_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
